// ===== hdl/tpqm_pkg.sv =====
// Shared constants, types and the quad check for the triangle pair quad merger.
package tpqm_pkg;

  localparam int MAX_CORNERS  = 128;
  localparam int INDEX_BITS   = 16;
  localparam int VERTEX_LIMIT = 128;
  localparam int CORNER_W     = 16;
  localparam int VIDX_W       = 7;
  localparam int VCOUNT_W     = 8;
  localparam int TOTAL_W      = $clog2(MAX_CORNERS + 1);
  localparam int SUM_W        = TOTAL_W + 1;
  localparam int QUEUE_DEPTH  = 4;

  typedef enum logic [1:0] {
    OUT_OK       = 2'd0,
    OUT_RANGE    = 2'd1,
    OUT_CAPACITY = 2'd2
  } outcome_e;

  typedef logic [3:0][CORNER_W-1:0] quad_t;

  // One queued job: up to two checked quads, then an optional error beat.
  typedef struct packed {
    logic [7:0][VIDX_W-1:0] idx;
    logic [1:0]             nquad;
    outcome_e               err;
    logic                   fin;
  } job_t;

  // Range check on all four corners first, then the mesh capacity check.
  function automatic outcome_e check_quad(input quad_t q, input logic [VCOUNT_W-1:0] lim,
                                          input logic [SUM_W-1:0] base);
    logic range_bad;
    range_bad = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (q[i] >= CORNER_W'(lim)) range_bad = 1'b1;
    end
    if (range_bad) return OUT_RANGE;
    else if (base + SUM_W'(4) > SUM_W'(MAX_CORNERS)) return OUT_CAPACITY;
    else return OUT_OK;
  endfunction

endpackage

// ===== hdl/tpqm_front.sv =====
// Front end: accepts triangles, merges pairs, checks quads and queues output jobs.
module tpqm_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tpqm_pkg::CORNER_W-1:0] corner_a_i,
  input  logic [tpqm_pkg::CORNER_W-1:0] corner_b_i,
  input  logic [tpqm_pkg::CORNER_W-1:0] corner_c_i,
  input  logic                          final_triangle_i,
  input  logic [tpqm_pkg::VCOUNT_W-1:0] vertex_count_i,
  input  logic                          full_i,
  output logic                          push_o,
  output tpqm_pkg::job_t                job_o
);
  import tpqm_pkg::*;

  localparam logic [CORNER_W-1:0] IDX_MASK = (INDEX_BITS >= CORNER_W) ? {CORNER_W{1'b1}}
                                           : CORNER_W'((64'd1 << INDEX_BITS) - 64'd1);

  logic [2:0][CORNER_W-1:0] tri_in;
  logic [2:0][CORNER_W-1:0] held_q;
  logic                     held_valid_q, held_valid_d;
  logic                     discard_q, discard_d;
  logic [TOTAL_W-1:0]       total_q, total_d;
  logic                     load_held;

  logic                     merge_hit;
  quad_t                    merge_quad, held_deg, tri_deg, quad_a, quad_b;
  logic [VCOUNT_W-1:0]      lim;
  logic [SUM_W-1:0]         base;
  outcome_e                 code_a, code_b;
  logic                     two_quads, accept, emit;

  assign tri_in[0] = corner_a_i & IDX_MASK;
  assign tri_in[1] = corner_b_i & IDX_MASK;
  assign tri_in[2] = corner_c_i & IDX_MASK;

  assign lim  = (vertex_count_i > VCOUNT_W'(VERTEX_LIMIT)) ? VCOUNT_W'(VERTEX_LIMIT)
                                                           : vertex_count_i;
  assign base = SUM_W'(total_q);

  // The lowest pending edge wins, then the lowest incoming edge.
  always_comb begin
    merge_hit  = 1'b0;
    merge_quad = '0;
    for (int e = 2; e >= 0; e--) begin
      for (int s = 2; s >= 0; s--) begin
        if (tri_in[s] == held_q[(e + 1) % 3] && tri_in[(s + 1) % 3] == held_q[e]) begin
          merge_hit = 1'b1;
          if (e == 0) begin
            merge_quad[0] = held_q[0];
            merge_quad[1] = tri_in[(s + 2) % 3];
            merge_quad[2] = held_q[2];
            merge_quad[3] = held_q[1];
          end else begin
            merge_quad[0] = held_q[(e + 1) % 3];
            merge_quad[1] = held_q[(e + 2) % 3];
            merge_quad[2] = tri_in[(s + 2) % 3];
            merge_quad[3] = held_q[e];
          end
        end
      end
    end
  end

  assign held_deg = {held_q[2], held_q[2], held_q[1], held_q[0]};
  assign tri_deg  = {tri_in[2], tri_in[2], tri_in[1], tri_in[0]};
  assign quad_a   = held_valid_q ? (merge_hit ? merge_quad : held_deg) : tri_deg;
  assign quad_b   = tri_deg;

  assign code_a    = check_quad(quad_a, lim, base);
  assign code_b    = check_quad(quad_b, lim, base + SUM_W'(4));
  assign two_quads = held_valid_q && !merge_hit && final_triangle_i;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      job_o.idx[i]     = quad_a[i][VIDX_W-1:0];
      job_o.idx[i + 4] = quad_b[i][VIDX_W-1:0];
    end
    job_o.fin = final_triangle_i;
    if (code_a != OUT_OK) begin
      job_o.nquad = 2'd0;
      job_o.err   = code_a;
    end else if (two_quads) begin
      job_o.nquad = (code_b == OUT_OK) ? 2'd2 : 2'd1;
      job_o.err   = code_b;
    end else begin
      job_o.nquad = 2'd1;
      job_o.err   = OUT_OK;
    end
  end

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign emit       = !discard_q && (held_valid_q || final_triangle_i);
  assign push_o     = accept && emit;

  always_comb begin
    held_valid_d = held_valid_q;
    discard_d    = discard_q;
    total_d      = total_q;
    load_held    = 1'b0;
    if (accept) begin
      if (final_triangle_i) begin
        held_valid_d = 1'b0;
        discard_d    = 1'b0;
        total_d      = '0;
      end else if (discard_q) begin
        discard_d = 1'b1;
      end else if (held_valid_q && job_o.err != OUT_OK) begin
        held_valid_d = 1'b0;
        discard_d    = 1'b1;
      end else if (!held_valid_q) begin
        held_valid_d = 1'b1;
        load_held    = 1'b1;
      end else begin
        held_valid_d = !merge_hit;
        load_held    = !merge_hit;
        total_d      = TOTAL_W'(base + SUM_W'(4));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      discard_q    <= 1'b0;
      total_q      <= '0;
    end else begin
      held_valid_q <= held_valid_d;
      discard_q    <= discard_d;
      total_q      <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_held) held_q <= tri_in;
  end

endmodule

// ===== hdl/tpqm_queue.sv =====
// Small job queue that decouples the front end from the beat serializer.
module tpqm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tpqm_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output tpqm_pkg::job_t job_o,
  output logic           empty_o
);
  import tpqm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t                mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]      count_q;

  assign full_o  = (count_q == (PTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

endmodule

// ===== hdl/tpqm_back.sv =====
// Back end: turns queued jobs into result beats behind an output register.
module tpqm_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  tpqm_pkg::job_t              job_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tpqm_pkg::VIDX_W-1:0] vertex_index_o,
  output logic [1:0]                  outcome_o,
  output logic                        run_end_o,
  output logic                        mesh_end_o
);
  import tpqm_pkg::*;

  logic [2:0]        beat_q;
  logic [3:0]        quad_beats, total_beats;
  logic              err_beat, last_beat, advance;
  logic              out_valid_q;
  logic [VIDX_W-1:0] vidx_q;
  outcome_e          outcome_q;
  logic              run_end_q, mesh_end_q;

  assign quad_beats  = {job_i.nquad, 2'b00};
  assign total_beats = quad_beats + {3'd0, job_i.err != OUT_OK};
  assign err_beat    = ({1'b0, beat_q} >= quad_beats);
  assign last_beat   = ({1'b0, beat_q} == total_beats - 4'd1);
  assign advance     = !empty_i && (!out_valid_q || out_ready_i);
  assign pop_o       = advance && last_beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      beat_q      <= last_beat ? 3'd0 : beat_q + 3'd1;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      vidx_q     <= err_beat ? '0 : job_i.idx[beat_q];
      outcome_q  <= err_beat ? job_i.err : OUT_OK;
      run_end_q  <= last_beat;
      mesh_end_q <= last_beat && (job_i.err != OUT_OK || job_i.fin);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign vertex_index_o = vidx_q;
  assign outcome_o      = outcome_q;
  assign run_end_o      = run_end_q;
  assign mesh_end_o     = mesh_end_q;

endmodule

// ===== hdl/triangle_pair_quad_merger_unit.sv =====
// Top level of the triangle pair quad merger: front end, job queue, beat serializer.
//
// Triangles arrive one per input beat and one is held pending; when the next triangle
// runs a pending edge backwards the two leave as one quad, otherwise the pending one
// leaves as the degenerate quad (a,b,c,c), and the final triangle of a mesh flushes
// it. Every quad is checked against vertex_count (values above 128 act as 128) and the
// mesh capacity before any corner goes out; a failure sends one error beat with
// mesh_end set and the rest of the mesh is dropped up to its final triangle. The
// front end takes a new triangle in every cycle while the four-entry job queue has
// room. The result channel runs one corner beat per cycle from the output register
// while jobs are queued and the receiver is ready, and a triangle yields zero, one,
// four, five or eight results, about two on a fully merged mesh and four when nothing
// merges. Results pass through the job queue and the output register. The
// vertex_count register is written through its own beat channel, which is always
// ready, and it should change only while the block is idle.
module triangle_pair_quad_merger_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tpqm_pkg::VCOUNT_W-1:0] cfg_vertex_count_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tpqm_pkg::CORNER_W-1:0] corner_a_i,
  input  logic [tpqm_pkg::CORNER_W-1:0] corner_b_i,
  input  logic [tpqm_pkg::CORNER_W-1:0] corner_c_i,
  input  logic                          final_triangle_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tpqm_pkg::VIDX_W-1:0]   vertex_index_o,
  output logic [1:0]                    outcome_o,
  output logic                          run_end_o,
  output logic                          mesh_end_o
);
  import tpqm_pkg::*;

  logic [VCOUNT_W-1:0] vertex_count_q;
  logic                push, pop, q_full, q_empty;
  job_t                push_job, head_job;

  // The configuration channel never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= VCOUNT_W'(VERTEX_LIMIT);
    end else if (cfg_valid_i) begin
      vertex_count_q <= cfg_vertex_count_i;
    end
  end

  // The front end decides every outcome, including errors, at accept time.
  tpqm_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .corner_a_i       (corner_a_i),
    .corner_b_i       (corner_b_i),
    .corner_c_i       (corner_c_i),
    .final_triangle_i (final_triangle_i),
    .vertex_count_i   (vertex_count_q),
    .full_i           (q_full),
    .push_o           (push),
    .job_o            (push_job)
  );

  tpqm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .job_o   (head_job),
    .empty_o (q_empty)
  );

  // The back end only expands queued jobs into beats.
  tpqm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (q_empty),
    .job_i          (head_job),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .vertex_index_o (vertex_index_o),
    .outcome_o      (outcome_o),
    .run_end_o      (run_end_o),
    .mesh_end_o     (mesh_end_o)
  );

  // An error beat always closes both its run and the mesh.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o != OUT_OK) |-> run_end_o && mesh_end_o)
    else $error("error beat without run_end and mesh_end");

  // The end of a mesh is also the end of a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mesh_end_o |-> run_end_o)
    else $error("mesh_end without run_end");

  // Error beats never carry a corner index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o != OUT_OK) |-> vertex_index_o == '0)
    else $error("error beat with nonzero vertex index");

  // A job is only popped when one is there.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("job queue underflow");

  // A job is only pushed when there is room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("job queue overflow");

endmodule

// ===== tb/sv/triangle_pair_quad_merger_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the triangle pair quad merger: directed meshes, then random traffic.
module triangle_pair_quad_merger_unit_tb;
  import tpqm_pkg::*;

  localparam int HALF_PERIOD   = 10;
  // Once the last expected beat has arrived the bench still lets this many cycles
  // pass, so that a stray extra beat shows up before it touches the register or
  // ends the run.
  localparam int SETTLE_CYCLES = 16;
  // The slowest correct run is far below this, even with eight beats per triangle
  // and the receiver idling most of the time.
  localparam int CYCLE_LIMIT   = 400000;

  typedef logic [2:0][CORNER_W-1:0] triangle_t;

  // One expected result beat.
  typedef struct {
    logic [VIDX_W-1:0] vidx;
    outcome_e          outcome;
    logic              run_end;
    logic              mesh_end;
  } corner_beat_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [VCOUNT_W-1:0] cfg_vertex_count_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [CORNER_W-1:0] corner_a_i;
  logic [CORNER_W-1:0] corner_b_i;
  logic [CORNER_W-1:0] corner_c_i;
  logic                final_triangle_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [VIDX_W-1:0]   vertex_index_o;
  logic [1:0]          outcome_o;
  logic                run_end_o;
  logic                mesh_end_o;

  // Idle rates in percent for the sender and the receiver.
  int send_idle_pct;
  int recv_idle_pct;

  int mismatch_count;
  int cycle_count;

  // Beats that the merger still owes us, oldest first.
  corner_beat_t beats_due[$];

  // Our own copy of the merger state and of its register.
  logic                pending_valid;
  triangle_t           pending_tri;
  int                  mesh_corners;
  logic                dropping;
  logic [VCOUNT_W-1:0] vcount_model;

  triangle_pair_quad_merger_unit i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_vertex_count_i (cfg_vertex_count_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .corner_a_i         (corner_a_i),
    .corner_b_i         (corner_b_i),
    .corner_c_i         (corner_c_i),
    .final_triangle_i   (final_triangle_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .vertex_index_o     (vertex_index_o),
    .outcome_o          (outcome_o),
    .run_end_o          (run_end_o),
    .mesh_end_o         (mesh_end_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Cycle counter that ends a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // The receiver stalls at random at the current idle rate.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Every accepted result beat is held against the oldest expected beat.
  always @(posedge clk_i) begin : check_beats
    corner_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (beats_due.size() == 0) begin
        $display("%0t: unexpected beat: index %0d outcome %0d run_end %0b mesh_end %0b",
                 $time, vertex_index_o, outcome_o, run_end_o, mesh_end_o);
        mismatch_count++;
      end else begin
        want = beats_due.pop_front();
        if (vertex_index_o !== want.vidx) begin
          $display("%0t: vertex_index expected %0d actual %0d", $time, want.vidx,
                   vertex_index_o);
          mismatch_count++;
        end
        if (outcome_o !== want.outcome) begin
          $display("%0t: outcome expected %0d actual %0d", $time, want.outcome, outcome_o);
          mismatch_count++;
        end
        if (run_end_o !== want.run_end) begin
          $display("%0t: run_end expected %0b actual %0b", $time, want.run_end, run_end_o);
          mismatch_count++;
        end
        if (mesh_end_o !== want.mesh_end) begin
          $display("%0t: mesh_end expected %0b actual %0b", $time, want.mesh_end,
                   mesh_end_o);
          mismatch_count++;
        end
      end
    end
  end

  function automatic triangle_t tri3(input int a, input int b, input int c);
    triangle_t t;
    t[0] = CORNER_W'(a);
    t[1] = CORNER_W'(b);
    t[2] = CORNER_W'(c);
    return t;
  endfunction

  // Degenerate quad (a,b,c,c) of a triangle that found no partner.
  function automatic quad_t degenerate_quad(input triangle_t t);
    quad_t q;
    q[0] = t[0];
    q[1] = t[1];
    q[2] = t[2];
    q[3] = t[2];
    return q;
  endfunction

  // The pair merges when the new triangle runs one pending edge backwards. The
  // pending edges are tried in order, and the first edge gives its own corner order.
  function automatic logic find_merge(input triangle_t h, input triangle_t t, output quad_t q);
    logic [CORNER_W-1:0] u;
    logic [CORNER_W-1:0] v;
    logic [CORNER_W-1:0] uf;
    logic [CORNER_W-1:0] us;
    q = '0;
    for (int e = 0; e < 3; e++) begin
      u  = h[e];
      v  = h[(e + 1) % 3];
      uf = h[(e + 2) % 3];
      for (int s = 0; s < 3; s++) begin
        if (t[s] == v && t[(s + 1) % 3] == u) begin
          us = t[(s + 2) % 3];
          if (e == 0) begin
            q[0] = u;
            q[1] = us;
            q[2] = uf;
            q[3] = v;
          end else begin
            q[0] = v;
            q[1] = uf;
            q[2] = us;
            q[3] = u;
          end
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic void forget_mesh();
    pending_valid = 1'b0;
    mesh_corners  = 0;
    dropping      = 1'b0;
  endfunction

  // Checks one quad and queues its four corner beats, or one error beat. The range
  // check wins over the capacity check.
  task automatic emit_quad(input quad_t q, output logic ok);
    int           lim;
    corner_beat_t b;
    lim        = (vcount_model > VERTEX_LIMIT) ? VERTEX_LIMIT : vcount_model;
    ok         = 1'b1;
    b.run_end  = 1'b0;
    b.mesh_end = 1'b0;
    b.vidx     = '0;
    for (int i = 0; i < 4; i++) begin
      if (q[i] >= lim) ok = 1'b0;
    end
    if (!ok) begin
      b.outcome = OUT_RANGE;
      beats_due.push_back(b);
      return;
    end
    if (mesh_corners + 4 > MAX_CORNERS) begin
      ok        = 1'b0;
      b.outcome = OUT_CAPACITY;
      beats_due.push_back(b);
      return;
    end
    b.outcome = OUT_OK;
    for (int i = 0; i < 4; i++) begin
      b.vidx = q[i][VIDX_W-1:0];
      beats_due.push_back(b);
    end
    mesh_corners += 4;
  endtask

  // Works out the beats that one accepted triangle causes.
  task automatic predict_triangle(input triangle_t t, input logic fin);
    quad_t        q;
    logic         ok;
    int           n0;
    corner_beat_t last;
    ok = 1'b1;
    n0 = beats_due.size();
    if (dropping) begin
      // The rest of a failed mesh is swallowed; its final triangle ends the drop.
      if (fin) forget_mesh();
      return;
    end
    if (pending_valid) begin
      if (find_merge(pending_tri, t, q)) begin
        pending_valid = 1'b0;
        emit_quad(q, ok);
      end else begin
        emit_quad(degenerate_quad(pending_tri), ok);
        if (ok) begin
          if (fin) begin
            emit_quad(degenerate_quad(t), ok);
            pending_valid = 1'b0;
          end else begin
            pending_tri = t;
          end
        end
      end
    end else if (fin) begin
      emit_quad(degenerate_quad(t), ok);
    end else begin
      pending_tri   = t;
      pending_valid = 1'b1;
    end
    if (beats_due.size() > n0) begin
      last         = beats_due.pop_back();
      last.run_end = 1'b1;
      if (!ok || fin) last.mesh_end = 1'b1;
      beats_due.push_back(last);
    end
    if (fin) begin
      forget_mesh();
    end else if (!ok) begin
      pending_valid = 1'b0;
      dropping      = 1'b1;
    end
  endtask

  // Sends one triangle beat. Valid stays high from one beat to the next unless the
  // sender takes an idle cycle in between.
  task automatic send_triangle(input triangle_t t, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    corner_a_i       <= t[0];
    corner_b_i       <= t[1];
    corner_c_i       <= t[2];
    final_triangle_i <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_triangle(t, fin);
  endtask

  // Waits until every expected beat has arrived and the queue has drained.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_vertex_count(input logic [VCOUNT_W-1:0] value);
    settle_block();
    cfg_valid_i        <= 1'b1;
    cfg_vertex_count_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    vcount_model = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly indices below the current vertex count, a few anywhere from 0 to 255.
  function automatic logic [CORNER_W-1:0] small_index();
    int lim;
    lim = (vcount_model > VERTEX_LIMIT) ? VERTEX_LIMIT : vcount_model;
    if (lim == 0) lim = 1;
    if ($urandom_range(99) < 96) return CORNER_W'($urandom_range(lim - 1));
    return CORNER_W'($urandom_range(255));
  endfunction

  // Merges on each of the three pending edges, a shared edge in the same direction,
  // flushes by the final triangle, and a final triangle that does not merge. The register
  // still holds its reset value here.
  task automatic test_merge_and_flush();
    send_triangle(tri3(0, 1, 2), 1'b0);
    send_triangle(tri3(1, 0, 7), 1'b0);
    send_triangle(tri3(3, 4, 5), 1'b0);
    send_triangle(tri3(5, 4, 8), 1'b0);
    send_triangle(tri3(10, 11, 12), 1'b0);
    send_triangle(tri3(10, 12, 13), 1'b0);
    send_triangle(tri3(1, 2, 3), 1'b0);
    send_triangle(tri3(1, 2, 4), 1'b0);
    send_triangle(tri3(127, 126, 125), 1'b1);
    send_triangle(tri3(5, 6, 7), 1'b1);
    send_triangle(tri3(0, 1, 2), 1'b0);
    send_triangle(tri3(2, 0, 9), 1'b1);
  endtask

  // Out-of-range corners on a degenerate quad, on a final triangle and on a merged
  // quad; the first and the last are followed by the dropped remainder of the mesh.
  task automatic test_range_errors();
    send_triangle(tri3(127, 0, 65535), 1'b0);
    send_triangle(tri3(50, 51, 52), 1'b0);
    send_triangle(tri3(1, 0, 127), 1'b0);
    send_triangle(tri3(0, 1, 2), 1'b1);
    send_triangle(tri3(65535, 65535, 65535), 1'b1);
    send_triangle(tri3(0, 1, 2), 1'b0);
    send_triangle(tri3(2, 1, 65535), 1'b0);
    send_triangle(tri3(3, 3, 3), 1'b1);
  endtask

  // A vertex count of zero rejects everything, a count above the limit acts as the limit,
  // and a count of one admits only index zero.
  task automatic test_vertex_count_extremes();
    write_vertex_count(8'd0);
    send_triangle(tri3(0, 0, 0), 1'b1);
    write_vertex_count(8'd255);
    send_triangle(tri3(127, 0, 1), 1'b1);
    send_triangle(tri3(128, 0, 1), 1'b1);
    write_vertex_count(8'd1);
    send_triangle(tri3(0, 0, 0), 1'b0);
    send_triangle(tri3(0, 0, 0), 1'b1);
  endtask

  // Thirty-two degenerate quads fill the mesh to the exact limit; the flush of the
  // pending triangle by the final one then overflows it.
  task automatic test_capacity_limit();
    int base;
    write_vertex_count(8'd128);
    for (int i = 0; i < 33; i++) begin
      base = 3 * i;
      send_triangle(tri3(base, base + 1, base + 2), 1'b0);
    end
    send_triangle(tri3(1, 2, 3), 1'b1);
  endtask

  // Random meshes at one register setting. While a triangle is pending, half of the new
  // ones are built to merge with it; the rest are loose small triangles and full-width noise.
  task automatic test_random_traffic(input int n_items, input logic [VCOUNT_W-1:0] vcount,
                                     input int s_pct, input int r_pct);
    triangle_t t;
    logic      fin;
    int        roll;
    int        e;
    int        s;
    write_vertex_count(vcount);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int k = 0; k < n_items; k++) begin
      roll = $urandom_range(99);
      if (pending_valid && !dropping && roll < 50) begin
        e = $urandom_range(2);
        s = $urandom_range(2);
        t[s]           = pending_tri[(e + 1) % 3];
        t[(s + 1) % 3] = pending_tri[e];
        t[(s + 2) % 3] = small_index();
      end else if (roll < 95) begin
        for (int i = 0; i < 3; i++) t[i] = small_index();
      end else begin
        for (int i = 0; i < 3; i++) t[i] = CORNER_W'($urandom);
      end
      fin = ($urandom_range(99) < 12);
      send_triangle(t, fin);
    end
    // Close the mesh so that the next setting starts clean.
    send_triangle(tri3(small_index(), small_index(), small_index()), 1'b1);
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_valid_i        = 1'b0;
    cfg_vertex_count_i = '0;
    in_valid_i         = 1'b0;
    corner_a_i         = '0;
    corner_b_i         = '0;
    corner_c_i         = '0;
    final_triangle_i   = 1'b0;
    out_ready_i        = 1'b0;
    mismatch_count     = 0;
    cycle_count        = 0;
    send_idle_pct      = 29;
    recv_idle_pct      = 82;
    vcount_model       = 8'd128;
    forget_mesh();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_merge_and_flush();
    test_range_errors();
    test_vertex_count_extremes();
    test_capacity_limit();
    test_random_traffic(90, 8'd100, 29, 82);
    test_random_traffic(90, 8'd200, 82, 29);
    test_random_traffic(50, 8'd128, 0, 0);
    test_random_traffic(40, 8'd20, 0, 0);

    settle_block();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== triangle_pair_quad_merger_unit.f =====
hdl/tpqm_pkg.sv
hdl/tpqm_front.sv
hdl/tpqm_queue.sv
hdl/tpqm_back.sv
hdl/triangle_pair_quad_merger_unit.sv
tb/sv/triangle_pair_quad_merger_unit_tb.sv
